// ===== sv/tdc_pkg.sv =====
// Shared types, constants and formats of the two-loop discrete compensator.
package tdc_pkg;

   // Fixed-point formats
   localparam int FRAC_BITS      = 24;          // errors, arm outputs, sum
   localparam int COEF_FRAC_BITS = 16;          // loop coefficients
   localparam int PI_FRAC_BITS   = 30;
   localparam int ERR_SHIFT      = PI_FRAC_BITS - FRAC_BITS;

   // Field and register widths
   localparam int COUNT_W     = 16;
   localparam int REF_W       = 10;
   localparam int COEF_W      = 24;
   localparam int STATE_W     = 32;
   localparam int DRIVE_W     = 9;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_REF_DEGREES    = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_COEF_ERR_NOW   = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] REG_COEF_ERR_PREV1 = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] REG_COEF_ERR_PREV2 = CSR_INDEX_W'(3);
   localparam logic [CSR_INDEX_W-1:0] REG_COEF_OUT_PREV1 = CSR_INDEX_W'(4);
   localparam logic [CSR_INDEX_W-1:0] REG_COEF_OUT_PREV2 = CSR_INDEX_W'(5);
   localparam logic [CSR_INDEX_W-1:0] REG_PEND_GAIN      = CSR_INDEX_W'(6);
   localparam logic signed [REF_W-1:0] REF_RESET = REF_W'(90);

   // Shared multiplier: constant or coefficient times count, error or output
   localparam int MUL_A_W = COEF_W + 1;
   localparam int MUL_B_W = STATE_W;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = 64;

   // Angle scales, pi held with 30 fractional bits, each rounded once
   localparam longint PI_Q30 = 64'sd3373259426;
   localparam logic signed [MUL_A_W-1:0] K_REF  = MUL_A_W'((PI_Q30 + 3600 / 2) / 3600);
   localparam logic signed [MUL_A_W-1:0] K_ARM  = MUL_A_W'((PI_Q30 + 2880 / 2) / 2880);
   localparam logic signed [MUL_A_W-1:0] K_PEND = MUL_A_W'((PI_Q30 + 20000 / 2) / 20000);

   // Error rounding back to FRAC_BITS (no rounding when the shift is zero)
   localparam logic signed [ACC_W-1:0] ERR_HALF =
      (ERR_SHIFT > 0) ? (64'sd1 <<< (ERR_SHIFT - 1)) : 64'sd0;
   localparam logic signed [ACC_W-1:0] ERR_HALF_NEG =
      (ERR_SHIFT > 0) ? (ERR_HALF - 64'sd1) : 64'sd0;

   // Arm loop: times 9/10 and back from the coefficient format
   localparam longint ARM_DIVISOR   = 10;
   localparam int     ARM_PRE_SHIFT = COEF_FRAC_BITS;
   localparam logic [ACC_W-1:0] ARM_HALF     = ACC_W'((ARM_DIVISOR << ARM_PRE_SHIFT) / 2);
   localparam logic [ACC_W-1:0] ARM_HALF_NEG = ARM_HALF + ACC_W'(1);
   localparam int M_W = ACC_W - ARM_PRE_SHIFT;
   localparam logic [M_W-1:0] ARM_SAT_M = M_W'(ARM_DIVISOR << (STATE_W - 1));

   // Divide-by-ten unit
   localparam int DIV_W       = $clog2(ARM_DIVISOR << (STATE_W - 1));
   localparam int DIV_DIGIT   = 5;
   localparam int DIV_STEPS   = (DIV_W + DIV_DIGIT - 1) / DIV_DIGIT;
   localparam int DIV_PAD_W   = DIV_STEPS * DIV_DIGIT;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
   localparam int DIV_REM_W   = $clog2(ARM_DIVISOR);
   localparam int DIV_TRIAL_W = DIV_REM_W + 1;

   // Pendulum loop: times 3/2 and back from the coefficient format
   localparam int U2_SHIFT = COEF_FRAC_BITS + 1;
   localparam logic signed [ACC_W-1:0] U2_HALF     = 64'sd1 <<< (U2_SHIFT - 1);
   localparam logic signed [ACC_W-1:0] U2_HALF_NEG = U2_HALF - 64'sd1;

   // Sum, clamp and drive scaling
   localparam int UK_W = STATE_W + 3;
   localparam logic signed [UK_W-1:0] UK_LIM = UK_W'(64'sd5 <<< FRAC_BITS);
   localparam int DRV_W = UK_W + 7;
   localparam logic signed [DRV_W-1:0] DRIVE_GAIN   = DRV_W'(51);
   localparam logic signed [DRV_W-1:0] DRV_HALF     = DRV_W'(64'sd1 <<< (FRAC_BITS - 1));
   localparam logic signed [DRV_W-1:0] DRV_HALF_NEG = DRV_HALF - DRV_W'(1);

   typedef struct packed {
      logic signed [COUNT_W-1:0] arm_count;
      logic signed [COUNT_W-1:0] pendulum_count;
   } req_type;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] drive;
      logic                      saturated;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_REF,
      ST_ARM,
      ST_PEND,
      ST_ERR_ARM,
      ST_ERR_PEND,
      ST_OUT_P1,
      ST_OUT_P2,
      ST_ERR_P1,
      ST_ERR_P2,
      ST_PEND_GAIN,
      ST_SCALE,
      ST_MAG,
      ST_DIV,
      ST_ARM_OUT,
      ST_CLAMP,
      ST_DRIVE
   } state_type;

   typedef enum logic [3:0] {
      MUL_REF,
      MUL_ARM,
      MUL_PEND,
      MUL_ERR_NOW,
      MUL_OUT_P1,
      MUL_OUT_P2,
      MUL_ERR_P1,
      MUL_ERR_P2,
      MUL_PEND_GAIN
   } mul_sel_type;

   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD,
      ACC_SUB,
      ACC_NEG,
      ACC_TIMES9
   } acc_op_type;

   typedef struct packed {
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        in_load;
      logic        err_arm_load;
      logic        err_pend_load;
      logic        u2_load;
      logic        div_start;
      logic        arm_out_load;
      logic        clamp_load;
      logic        rsp_load;
   } cmd_type;

   typedef struct packed {
      logic div_last;
      logic rsp_free;
   } status_type;

endpackage

// ===== sv/tdc_div10.sv =====
// Iterative divide-by-ten unit, several quotient bits per cycle.
module tdc_div10 (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tdc_pkg::DIV_W-1:0]     dividend,
   output logic [tdc_pkg::STATE_W-1:0]   quotient,
   output logic                          last
);

   logic [tdc_pkg::DIV_PAD_W-1:0] work_ff, work_in;
   logic [tdc_pkg::DIV_REM_W-1:0] rem_ff, rem_in;
   logic [tdc_pkg::DIV_CNT_W-1:0] count_ff, count_in;
   logic                          busy_ff, busy_in;
   logic [tdc_pkg::DIV_PAD_W-1:0] work_step;
   logic [tdc_pkg::DIV_REM_W-1:0] rem_step;
   logic [tdc_pkg::DIV_TRIAL_W-1:0] trial;

   // restoring division; quotient bits shift in as dividend bits shift out
   always_comb begin
      rem_step  = rem_ff;
      work_step = work_ff;
      trial     = '0;
      for (int i = 0; i < tdc_pkg::DIV_DIGIT; i++) begin
         trial     = {rem_step, work_step[tdc_pkg::DIV_PAD_W-1]};
         work_step = {work_step[tdc_pkg::DIV_PAD_W-2:0], 1'b0};
         if (trial >= tdc_pkg::DIV_TRIAL_W'(tdc_pkg::ARM_DIVISOR)) begin
            trial        = trial - tdc_pkg::DIV_TRIAL_W'(tdc_pkg::ARM_DIVISOR);
            work_step[0] = 1'b1;
         end
         rem_step = trial[tdc_pkg::DIV_REM_W-1:0];
      end
   end

   always_comb begin
      work_in  = work_ff;
      rem_in   = rem_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      if (start) begin
         work_in  = tdc_pkg::DIV_PAD_W'(dividend);
         rem_in   = '0;
         count_in = tdc_pkg::DIV_CNT_W'(tdc_pkg::DIV_STEPS);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         work_in  = work_step;
         rem_in   = rem_step;
         count_in = count_ff - tdc_pkg::DIV_CNT_W'(1);
         busy_in  = (count_ff != tdc_pkg::DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
   end

   assign last     = busy_ff && (count_ff == tdc_pkg::DIV_CNT_W'(1));
   assign quotient = work_ff[tdc_pkg::STATE_W-1:0];

endmodule

// ===== sv/tdc_dp.sv =====
// Datapath: registers, shared multiplier, accumulator, history and result register.
module tdc_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  tdc_pkg::cmd_type                  cmd,
   output tdc_pkg::status_type               status,
   input  tdc_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output tdc_pkg::rsp_type                  rsp_data,
   input  logic                              csr_write,
   input  logic [tdc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tdc_pkg::CSR_DATA_W-1:0]    csr_data
);

   // configuration
   logic signed [tdc_pkg::REF_W-1:0]  ref_ff;
   logic signed [tdc_pkg::COEF_W-1:0] coef_err_now_ff, coef_err_prev1_ff, coef_err_prev2_ff;
   logic signed [tdc_pkg::COEF_W-1:0] coef_out_prev1_ff, coef_out_prev2_ff, pend_gain_ff;

   // history
   logic signed [tdc_pkg::STATE_W-1:0] err_p1_ff, err_p2_ff, out_p1_ff, out_p2_ff;

   // working registers
   logic signed [tdc_pkg::COUNT_W-1:0] arm_ff, pend_ff;
   logic signed [tdc_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic signed [tdc_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic signed [tdc_pkg::STATE_W-1:0] e1_ff, e2_ff, u2_ff;
   logic                               neg_ff, over_ff;
   logic signed [tdc_pkg::UK_W-1:0]    uk_ff, uk_in;
   logic                               sat_ff, sat_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   tdc_pkg::rsp_type                   rsp_data_ff, rsp_data_in;

   logic signed [tdc_pkg::MUL_A_W-1:0] mul_a;
   logic signed [tdc_pkg::MUL_B_W-1:0] mul_b;
   logic signed [tdc_pkg::ACC_W-1:0]   prod_ext;
   logic signed [tdc_pkg::ACC_W-1:0]   u2_wide;
   logic signed [tdc_pkg::STATE_W-1:0] u2_in;
   logic                               acc_neg;
   logic [tdc_pkg::ACC_W-1:0]          mag;
   logic [tdc_pkg::M_W-1:0]            mag_m;
   logic                               over_in;
   logic [tdc_pkg::STATE_W-1:0]        quotient;
   logic                               div_last;
   logic signed [tdc_pkg::STATE_W-1:0] u1_in;
   logic signed [tdc_pkg::UK_W-1:0]    u_sum;
   logic signed [tdc_pkg::DRV_W-1:0]   drv_prod, drv_round;
   logic                               rsp_free;

   function automatic logic signed [tdc_pkg::STATE_W-1:0] sat32(
      input logic signed [tdc_pkg::ACC_W-1:0] v
   );
      logic signed [tdc_pkg::STATE_W-1:0] r;
      if (v > 64'sd2147483647)
         r = 32'sh7fffffff;
      else if (v < -64'sd2147483648)
         r = 32'sh80000000;
      else
         r = v[tdc_pkg::STATE_W-1:0];
      return r;
   endfunction

   // round to nearest, ties away from zero, from pi's 30 fraction bits
   function automatic logic signed [tdc_pkg::STATE_W-1:0] err_round(
      input logic signed [tdc_pkg::ACC_W-1:0] a
   );
      logic signed [tdc_pkg::ACC_W-1:0] b;
      b = a + (a[tdc_pkg::ACC_W-1] ? tdc_pkg::ERR_HALF_NEG : tdc_pkg::ERR_HALF);
      b = b >>> tdc_pkg::ERR_SHIFT;
      return sat32(b);
   endfunction

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff            <= tdc_pkg::REF_RESET;
         coef_err_now_ff   <= '0;
         coef_err_prev1_ff <= '0;
         coef_err_prev2_ff <= '0;
         coef_out_prev1_ff <= '0;
         coef_out_prev2_ff <= '0;
         pend_gain_ff      <= '0;
      end else if (csr_write) begin
         case (csr_index)
            tdc_pkg::REG_REF_DEGREES:    ref_ff <= csr_data[tdc_pkg::REF_W-1:0];
            tdc_pkg::REG_COEF_ERR_NOW:   coef_err_now_ff <= csr_data;
            tdc_pkg::REG_COEF_ERR_PREV1: coef_err_prev1_ff <= csr_data;
            tdc_pkg::REG_COEF_ERR_PREV2: coef_err_prev2_ff <= csr_data;
            tdc_pkg::REG_COEF_OUT_PREV1: coef_out_prev1_ff <= csr_data;
            tdc_pkg::REG_COEF_OUT_PREV2: coef_out_prev2_ff <= csr_data;
            tdc_pkg::REG_PEND_GAIN:      pend_gain_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // shared multiplier operands
   always_comb begin
      case (cmd.mul_sel)
         tdc_pkg::MUL_REF: begin
            mul_a = tdc_pkg::K_REF;
            mul_b = {{(tdc_pkg::MUL_B_W-tdc_pkg::REF_W){ref_ff[tdc_pkg::REF_W-1]}}, ref_ff};
         end
         tdc_pkg::MUL_ARM: begin
            mul_a = tdc_pkg::K_ARM;
            mul_b = {{(tdc_pkg::MUL_B_W-tdc_pkg::COUNT_W){arm_ff[tdc_pkg::COUNT_W-1]}}, arm_ff};
         end
         tdc_pkg::MUL_PEND: begin
            mul_a = tdc_pkg::K_PEND;
            mul_b = {{(tdc_pkg::MUL_B_W-tdc_pkg::COUNT_W){pend_ff[tdc_pkg::COUNT_W-1]}},
                     pend_ff};
         end
         tdc_pkg::MUL_ERR_NOW: begin
            mul_a = {coef_err_now_ff[tdc_pkg::COEF_W-1], coef_err_now_ff};
            mul_b = e1_ff;
         end
         tdc_pkg::MUL_OUT_P1: begin
            mul_a = {coef_out_prev1_ff[tdc_pkg::COEF_W-1], coef_out_prev1_ff};
            mul_b = out_p1_ff;
         end
         tdc_pkg::MUL_OUT_P2: begin
            mul_a = {coef_out_prev2_ff[tdc_pkg::COEF_W-1], coef_out_prev2_ff};
            mul_b = out_p2_ff;
         end
         tdc_pkg::MUL_ERR_P1: begin
            mul_a = {coef_err_prev1_ff[tdc_pkg::COEF_W-1], coef_err_prev1_ff};
            mul_b = err_p1_ff;
         end
         tdc_pkg::MUL_ERR_P2: begin
            mul_a = {coef_err_prev2_ff[tdc_pkg::COEF_W-1], coef_err_prev2_ff};
            mul_b = err_p2_ff;
         end
         tdc_pkg::MUL_PEND_GAIN: begin
            mul_a = {pend_gain_ff[tdc_pkg::COEF_W-1], pend_gain_ff};
            mul_b = e2_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   assign prod_ext = {{(tdc_pkg::ACC_W-tdc_pkg::PROD_W){prod_ff[tdc_pkg::PROD_W-1]}}, prod_ff};

   always_comb begin
      case (cmd.acc_op)
         tdc_pkg::ACC_HOLD:   acc_in = acc_ff;
         tdc_pkg::ACC_LOAD:   acc_in = prod_ext;
         tdc_pkg::ACC_ADD:    acc_in = acc_ff + prod_ext;
         tdc_pkg::ACC_SUB:    acc_in = acc_ff - prod_ext;
         tdc_pkg::ACC_NEG:    acc_in = -prod_ext;
         tdc_pkg::ACC_TIMES9: acc_in = acc_ff + (acc_ff <<< 3);
         default:             acc_in = acc_ff;
      endcase
   end

   // pendulum loop: product times 3, halved and out of the coefficient format
   always_comb begin
      u2_wide = prod_ext + (prod_ext <<< 1);
      u2_wide = u2_wide + (u2_wide[tdc_pkg::ACC_W-1] ? tdc_pkg::U2_HALF_NEG : tdc_pkg::U2_HALF);
      u2_wide = u2_wide >>> tdc_pkg::U2_SHIFT;
      u2_in   = sat32(u2_wide);
   end

   // arm loop magnitude, pre-shifted by 2^16 so that only /10 is left
   always_comb begin
      acc_neg = acc_ff[tdc_pkg::ACC_W-1];
      mag     = (acc_neg ? ~acc_ff : acc_ff)
              + (acc_neg ? tdc_pkg::ARM_HALF_NEG : tdc_pkg::ARM_HALF);
      mag_m   = mag[tdc_pkg::ACC_W-1:tdc_pkg::ARM_PRE_SHIFT];
      over_in = (mag_m >= tdc_pkg::ARM_SAT_M);
   end

   tdc_div10 u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (mag_m[tdc_pkg::DIV_W-1:0]),
      .quotient (quotient),
      .last     (div_last)
   );

   always_comb begin
      if (over_ff)
         u1_in = neg_ff ? 32'sh80000000 : 32'sh7fffffff;
      else
         u1_in = neg_ff ? -$signed(quotient) : $signed(quotient);
   end

   // negated sum and the +-5 clamp
   always_comb begin
      u_sum = -({{(tdc_pkg::UK_W-tdc_pkg::STATE_W){out_p1_ff[tdc_pkg::STATE_W-1]}}, out_p1_ff}
              + {{(tdc_pkg::UK_W-tdc_pkg::STATE_W){u2_ff[tdc_pkg::STATE_W-1]}}, u2_ff});
      if (u_sum > tdc_pkg::UK_LIM) begin
         uk_in  = tdc_pkg::UK_LIM;
         sat_in = 1'b1;
      end else if (u_sum < -tdc_pkg::UK_LIM) begin
         uk_in  = -tdc_pkg::UK_LIM;
         sat_in = 1'b1;
      end else begin
         uk_in  = u_sum;
         sat_in = 1'b0;
      end
   end

   always_comb begin
      drv_prod  = {{(tdc_pkg::DRV_W-tdc_pkg::UK_W){uk_ff[tdc_pkg::UK_W-1]}}, uk_ff}
                * tdc_pkg::DRIVE_GAIN;
      drv_round = (drv_prod + (drv_prod[tdc_pkg::DRV_W-1] ? tdc_pkg::DRV_HALF_NEG
                                                          : tdc_pkg::DRV_HALF))
                >>> tdc_pkg::FRAC_BITS;
      rsp_data_in.drive     = drv_round[tdc_pkg::DRIVE_W-1:0];
      rsp_data_in.saturated = sat_ff;
   end

   assign rsp_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && rsp_stall);

   // history and output handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         err_p1_ff    <= '0;
         err_p2_ff    <= '0;
         out_p1_ff    <= '0;
         out_p2_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.arm_out_load) begin
            err_p2_ff <= err_p1_ff;
            err_p1_ff <= e1_ff;
            out_p2_ff <= out_p1_ff;
            out_p1_ff <= u1_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (cmd.in_load) begin
         arm_ff  <= req_data.arm_count;
         pend_ff <= req_data.pendulum_count;
      end
      if (cmd.err_arm_load)
         e1_ff <= err_round(acc_ff);
      if (cmd.err_pend_load)
         e2_ff <= err_round(acc_ff);
      if (cmd.u2_load)
         u2_ff <= u2_in;
      if (cmd.div_start) begin
         neg_ff  <= acc_neg;
         over_ff <= over_in;
      end
      if (cmd.clamp_load) begin
         uk_ff  <= uk_in;
         sat_ff <= sat_in;
      end
      if (cmd.rsp_load)
         rsp_data_ff <= rsp_data_in;
   end

   assign status.div_last = div_last;
   assign status.rsp_free = rsp_free;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

endmodule

// ===== sv/tdc_ctrl.sv =====
// Controller: sequences one item through the datapath.
module tdc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  tdc_pkg::status_type  status,
   output tdc_pkg::cmd_type     cmd
);

   tdc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= tdc_pkg::ST_IDLE;
      else
         state_ff <= state_in;
   end

   always_comb begin
      case (state_ff)
         tdc_pkg::ST_IDLE:      state_in = req_valid ? tdc_pkg::ST_REF : tdc_pkg::ST_IDLE;
         tdc_pkg::ST_REF:       state_in = tdc_pkg::ST_ARM;
         tdc_pkg::ST_ARM:       state_in = tdc_pkg::ST_PEND;
         tdc_pkg::ST_PEND:      state_in = tdc_pkg::ST_ERR_ARM;
         tdc_pkg::ST_ERR_ARM:   state_in = tdc_pkg::ST_ERR_PEND;
         tdc_pkg::ST_ERR_PEND:  state_in = tdc_pkg::ST_OUT_P1;
         tdc_pkg::ST_OUT_P1:    state_in = tdc_pkg::ST_OUT_P2;
         tdc_pkg::ST_OUT_P2:    state_in = tdc_pkg::ST_ERR_P1;
         tdc_pkg::ST_ERR_P1:    state_in = tdc_pkg::ST_ERR_P2;
         tdc_pkg::ST_ERR_P2:    state_in = tdc_pkg::ST_PEND_GAIN;
         tdc_pkg::ST_PEND_GAIN: state_in = tdc_pkg::ST_SCALE;
         tdc_pkg::ST_SCALE:     state_in = tdc_pkg::ST_MAG;
         tdc_pkg::ST_MAG:       state_in = tdc_pkg::ST_DIV;
         tdc_pkg::ST_DIV:       state_in = status.div_last ? tdc_pkg::ST_ARM_OUT
                                                           : tdc_pkg::ST_DIV;
         tdc_pkg::ST_ARM_OUT:   state_in = tdc_pkg::ST_CLAMP;
         tdc_pkg::ST_CLAMP:     state_in = tdc_pkg::ST_DRIVE;
         tdc_pkg::ST_DRIVE:     state_in = status.rsp_free ? tdc_pkg::ST_IDLE
                                                           : tdc_pkg::ST_DRIVE;
         default:               state_in = tdc_pkg::ST_IDLE;
      endcase
   end

   // multiply issued in a state is accumulated in the next one
   always_comb begin
      cmd.mul_sel       = tdc_pkg::MUL_REF;
      cmd.acc_op        = tdc_pkg::ACC_HOLD;
      cmd.in_load       = 1'b0;
      cmd.err_arm_load  = 1'b0;
      cmd.err_pend_load = 1'b0;
      cmd.u2_load       = 1'b0;
      cmd.div_start     = 1'b0;
      cmd.arm_out_load  = 1'b0;
      cmd.clamp_load    = 1'b0;
      cmd.rsp_load      = 1'b0;
      case (state_ff)
         tdc_pkg::ST_IDLE:      cmd.in_load = req_valid;
         tdc_pkg::ST_REF:       cmd.mul_sel = tdc_pkg::MUL_REF;
         tdc_pkg::ST_ARM: begin
            cmd.mul_sel = tdc_pkg::MUL_ARM;
            cmd.acc_op  = tdc_pkg::ACC_LOAD;
         end
         tdc_pkg::ST_PEND: begin
            cmd.mul_sel = tdc_pkg::MUL_PEND;
            cmd.acc_op  = tdc_pkg::ACC_SUB;
         end
         tdc_pkg::ST_ERR_ARM: begin
            cmd.acc_op       = tdc_pkg::ACC_NEG;
            cmd.err_arm_load = 1'b1;
         end
         tdc_pkg::ST_ERR_PEND: begin
            cmd.mul_sel       = tdc_pkg::MUL_ERR_NOW;
            cmd.err_pend_load = 1'b1;
         end
         tdc_pkg::ST_OUT_P1: begin
            cmd.mul_sel = tdc_pkg::MUL_OUT_P1;
            cmd.acc_op  = tdc_pkg::ACC_LOAD;
         end
         tdc_pkg::ST_OUT_P2: begin
            cmd.mul_sel = tdc_pkg::MUL_OUT_P2;
            cmd.acc_op  = tdc_pkg::ACC_ADD;
         end
         tdc_pkg::ST_ERR_P1: begin
            cmd.mul_sel = tdc_pkg::MUL_ERR_P1;
            cmd.acc_op  = tdc_pkg::ACC_ADD;
         end
         tdc_pkg::ST_ERR_P2: begin
            cmd.mul_sel = tdc_pkg::MUL_ERR_P2;
            cmd.acc_op  = tdc_pkg::ACC_ADD;
         end
         tdc_pkg::ST_PEND_GAIN: begin
            cmd.mul_sel = tdc_pkg::MUL_PEND_GAIN;
            cmd.acc_op  = tdc_pkg::ACC_SUB;   // term two ticks back is subtracted
         end
         tdc_pkg::ST_SCALE: begin
            cmd.acc_op  = tdc_pkg::ACC_TIMES9;
            cmd.u2_load = 1'b1;
         end
         tdc_pkg::ST_MAG:       cmd.div_start = 1'b1;
         tdc_pkg::ST_DIV:       ;
         tdc_pkg::ST_ARM_OUT:   cmd.arm_out_load = 1'b1;
         tdc_pkg::ST_CLAMP:     cmd.clamp_load = 1'b1;
         tdc_pkg::ST_DRIVE:     cmd.rsp_load = status.rsp_free;
         default: ;
      endcase
   end

   assign req_stall = (state_ff != tdc_pkg::ST_IDLE);

endmodule

// ===== sv/two_loop_discrete_compensator.sv =====
// Top level of the two-loop discrete compensator.
// One item per control tick: arm and pendulum encoder counts in, one drive value and a
// saturation flag out. From acceptance to the next acceptance an item passes the
// accepting state, then states in which nine products go one after another
// through a single shared 25x32 multiplier and accumulator and both errors are rounded,
// then the arm loop's times nine and the start of the division by ten, which runs in an
// iterative unit at five quotient bits a cycle, then the arm output, the sum and clamp,
// and the drive scaling. The result sits in an output register, so the next item is
// taken while it waits; a further result holds the controller, and with it the input,
// until the waiting one is taken. Registers are to be written through the csr port
// only while no item is in flight, which the block does not enforce; index 7 is ignored.
module two_loop_discrete_compensator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  tdc_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output tdc_pkg::rsp_type                  rsp_data,
   input  logic                              csr_write,
   input  logic [tdc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tdc_pkg::CSR_DATA_W-1:0]    csr_data
);

   tdc_pkg::cmd_type    cmd;
   tdc_pkg::status_type status;

   tdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tdc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

endmodule

// ===== tb/sv/tdc_checker.sv =====
// Channel monitor for the two-loop compensator: predicts every drive item and checks it.
`timescale 1ns / 100ps
module tdc_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  tdc_pkg::req_type                    req_data,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  tdc_pkg::rsp_type                    rsp_data,
   input  logic                                csr_write,
   input  logic [tdc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tdc_pkg::CSR_DATA_W-1:0]      csr_data,
   output int                                  fail_count,
   output int                                  pending_count,
   output int                                  checked_count,
   output int                                  clamped_count
);

   localparam int     FRAC      = tdc_pkg::FRAC_BITS;
   localparam longint ANGLE_PI  = 64'sd3373259426;             // pi with 30 fraction bits
   localparam longint K_REF_DEG = (ANGLE_PI + 1800) / 3600;     // 0.05 * pi/180
   localparam longint K_ARM_CNT = (ANGLE_PI + 1440) / 2880;     // 0.05 * pi/144
   localparam longint K_PEND_CNT = (ANGLE_PI + 10000) / 20000;  // 0.05 * pi/1000

   // register copies
   logic signed [tdc_pkg::REF_W-1:0]  ref_deg;
   logic signed [tdc_pkg::COEF_W-1:0] k_err_now, k_err_p1, k_err_p2, k_out_p1, k_out_p2;
   logic signed [tdc_pkg::COEF_W-1:0] k_pend;

   // arm loop history, stored before the clamp
   logic signed [tdc_pkg::STATE_W-1:0] err_z1, err_z2, out_z1, out_z2;

   tdc_pkg::rsp_type drive_forecast_q[$];

   function automatic longint round_div(longint n, longint d);
      if (n >= 0)
         return (n + d / 2) / d;
      return -((-n + d / 2) / d);
   endfunction

   function automatic logic signed [31:0] clip32(longint v);
      if (v > 64'sd2147483647)
         return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648)
         return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic tdc_pkg::rsp_type next_drive(tdc_pkg::req_type item);
      longint arm, pend, to_frac, sum, net, lim;
      logic signed [31:0] e_arm, e_pend, u_arm, u_pend;
      tdc_pkg::rsp_type r;
      arm     = longint'($signed(item.arm_count));
      pend    = longint'($signed(item.pendulum_count));
      to_frac = 64'sd1 <<< (30 - FRAC);
      lim     = 64'sd5 <<< FRAC;

      e_arm  = clip32(round_div(longint'(ref_deg) * K_REF_DEG - arm * K_ARM_CNT, to_frac));
      e_pend = clip32(round_div(-pend * K_PEND_CNT, to_frac));

      sum = longint'(k_out_p1) * longint'(out_z1)
          + longint'(k_out_p2) * longint'(out_z2)
          + longint'(k_err_now) * longint'(e_arm)
          + longint'(k_err_p1) * longint'(err_z1)
          - longint'(k_err_p2) * longint'(err_z2);
      // 0.9 and 1.5 folded into the single rounding back from Q8.16
      u_arm  = clip32(round_div(sum * 9, 64'sd10 * 64'sd65536));
      u_pend = clip32(round_div(longint'(k_pend) * longint'(e_pend) * 3, 64'sd2 * 64'sd65536));

      net = -(longint'(u_arm) + longint'(u_pend));

      err_z2 = err_z1;
      err_z1 = e_arm;
      out_z2 = out_z1;
      out_z1 = u_arm;

      r.saturated = 1'b0;
      if (net > lim) begin
         net = lim;
         r.saturated = 1'b1;
      end else if (net < -lim) begin
         net = -lim;
         r.saturated = 1'b1;
      end
      r.drive = tdc_pkg::DRIVE_W'(round_div(net * 51, 64'sd1 <<< FRAC));
      return r;
   endfunction

   task automatic report(input string what);
      $display("%0t ns  check: %s", $time, what);
      fail_count++;
   endtask

   always @(posedge clock) begin
      tdc_pkg::rsp_type want;
      if (reset) begin
         ref_deg   = tdc_pkg::REF_RESET;
         k_err_now = '0;
         k_err_p1  = '0;
         k_err_p2  = '0;
         k_out_p1  = '0;
         k_out_p2  = '0;
         k_pend    = '0;
         err_z1    = '0;
         err_z2    = '0;
         out_z1    = '0;
         out_z2    = '0;
         drive_forecast_q.delete();
         fail_count    = 0;
         checked_count = 0;
         clamped_count = 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               tdc_pkg::REG_REF_DEGREES:    ref_deg   = csr_data[tdc_pkg::REF_W-1:0];
               tdc_pkg::REG_COEF_ERR_NOW:   k_err_now = csr_data;
               tdc_pkg::REG_COEF_ERR_PREV1: k_err_p1  = csr_data;
               tdc_pkg::REG_COEF_ERR_PREV2: k_err_p2  = csr_data;
               tdc_pkg::REG_COEF_OUT_PREV1: k_out_p1  = csr_data;
               tdc_pkg::REG_COEF_OUT_PREV2: k_out_p2  = csr_data;
               tdc_pkg::REG_PEND_GAIN:      k_pend    = csr_data;
               default: ;
            endcase
         end
         // result first: an item accepted on this edge cannot already be answered
         if (rsp_valid && !rsp_stall) begin
            if (drive_forecast_q.size() == 0) begin
               report($sformatf("drive item with none outstanding (drive %0d, sat %b)",
                                $signed(rsp_data.drive), rsp_data.saturated));
            end else begin
               want = drive_forecast_q.pop_front();
               if (rsp_data.drive !== want.drive)
                  report($sformatf("drive: expected %0d, got %0d",
                                   $signed(want.drive), $signed(rsp_data.drive)));
               if (rsp_data.saturated !== want.saturated)
                  report($sformatf("saturated: expected %b, got %b",
                                   want.saturated, rsp_data.saturated));
               checked_count++;
               if (want.saturated)
                  clamped_count++;
            end
         end
         if (req_valid && !req_stall)
            drive_forecast_q.push_back(next_drive(req_data));
      end
      pending_count = drive_forecast_q.size();
   end

endmodule

// ===== tb/sv/tb.sv =====
// Top of the compensator testbench: clock, reset, register settings, items and verdict.
`timescale 1ns / 100ps
module tb;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS   = 108;
   localparam int HOLD_CYCLES   = 300;
   localparam logic [tdc_pkg::CSR_INDEX_W-1:0] REG_UNUSED = '1;

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   tdc_pkg::req_type                  req_data;
   logic                              rsp_valid;
   logic                              rsp_stall;
   tdc_pkg::rsp_type                  rsp_data;
   logic                              csr_write;
   logic [tdc_pkg::CSR_INDEX_W-1:0]   csr_index;
   logic [tdc_pkg::CSR_DATA_W-1:0]    csr_data;

   int fail_count, pending_count, checked_count, clamped_count;
   int items_sent, settings_used, cycle_count, holds_done;
   int arm_walk, pend_walk;
   logic signed [tdc_pkg::REF_W-1:0] ref_now;

   two_loop_discrete_compensator DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   tdc_checker drive_watch (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count),
      .clamped_count (clamped_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timed out after %0d cycles, %0d items still awaited", cycle_count,
               pending_count);
      $display("FAIL two_loop_discrete_compensator");
      $finish;
   end

   // receiver: stall pattern changes per segment, plus two long hold-offs mid-run
   initial begin
      int mode;
      int seg;
      rsp_stall  = 1'b0;
      holds_done = 0;
      wait (reset === 1'b0);
      forever begin
         mode = $urandom_range(0, 3);
         seg  = $urandom_range(20, 200);
         repeat (seg) begin
            @(negedge clock);
            if (holds_done < 2 && checked_count >= 200 + 300 * holds_done) begin
               rsp_stall = 1'b1;
               repeat (HOLD_CYCLES) @(negedge clock);
               holds_done++;
            end
            case (mode)
               0: rsp_stall = 1'b0;
               1: rsp_stall = ($urandom_range(0, 3) == 0);
               2: rsp_stall = ($urandom_range(0, 3) != 0);
               default: rsp_stall = ~rsp_stall;
            endcase
         end
      end
   end

   task automatic offer(input logic signed [15:0] arm, input logic signed [15:0] pend);
      req_data.arm_count      = arm;
      req_data.pendulum_count = pend;
      req_valid               = 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic pause_sender(input int cycles);
      req_valid = 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // block idle: every item answered
   task automatic settle();
      req_valid = 1'b0;
      wait (pending_count == 0);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_reg(input logic [tdc_pkg::CSR_INDEX_W-1:0] index,
                            input logic [tdc_pkg::CSR_DATA_W-1:0] value);
      csr_write = 1'b1;
      csr_index = index;
      csr_data  = value;
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   function automatic logic [tdc_pkg::CSR_DATA_W-1:0] wild_coef();
      case ($urandom_range(0, 3))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         default: return 24'($urandom);
      endcase
   endfunction

   // span in Q8.16 units either side of zero
   function automatic logic [tdc_pkg::CSR_DATA_W-1:0] tame_coef(input int span);
      return 24'(int'($urandom_range(0, 2 * span)) - span);
   endfunction

   task automatic load_setting();
      logic wild;
      wild = ($urandom_range(0, 3) == 0);
      if (wild) begin
         case ($urandom_range(0, 4))
            0: ref_now = -10'sd512;
            1: ref_now = 10'sd511;
            2: ref_now = -10'sd360;
            3: ref_now = 10'sd360;
            default: ref_now = 10'($urandom);
         endcase
      end else begin
         ref_now = 10'(int'($urandom_range(0, 720)) - 360);
      end
      write_reg(tdc_pkg::REG_REF_DEGREES, 24'(ref_now));
      write_reg(tdc_pkg::REG_COEF_ERR_NOW,   wild ? wild_coef() : tame_coef(131072));
      write_reg(tdc_pkg::REG_COEF_ERR_PREV1, wild ? wild_coef() : tame_coef(131072));
      write_reg(tdc_pkg::REG_COEF_ERR_PREV2, wild ? wild_coef() : tame_coef(131072));
      write_reg(tdc_pkg::REG_COEF_OUT_PREV1, wild ? wild_coef() : tame_coef(40000));
      write_reg(tdc_pkg::REG_COEF_OUT_PREV2, wild ? wild_coef() : tame_coef(40000));
      write_reg(tdc_pkg::REG_PEND_GAIN,      wild ? wild_coef() : tame_coef(524288));
      if ($urandom_range(0, 2) == 0)
         write_reg(REG_UNUSED, 24'($urandom));
      arm_walk  = int'(ref_now) * 4 / 5;
      pend_walk = 0;
      settings_used++;
   endtask

   // mostly a slow walk around the target, now and then a jump or an extreme
   task automatic next_counts(output logic signed [15:0] arm, output logic signed [15:0] pend);
      case ($urandom_range(0, 9))
         0: begin
            arm  = 16'($urandom);
            pend = 16'($urandom);
         end
         1: begin
            arm  = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            pend = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         end
         default: begin
            arm_walk  = arm_walk + int'($urandom_range(0, 16)) - 8;
            pend_walk = pend_walk + int'($urandom_range(0, 40)) - 20;
            if (arm_walk > 32767 || arm_walk < -32768)
               arm_walk = int'(ref_now) * 4 / 5;
            if (pend_walk > 1500 || pend_walk < -1500)
               pend_walk = 0;
            arm  = 16'(arm_walk);
            pend = 16'(pend_walk);
         end
      endcase
   endtask

   initial begin
      logic signed [15:0] a_cnt, p_cnt;
      int burst_left;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      csr_write     = 1'b0;
      csr_index     = '0;
      csr_data      = '0;
      items_sent    = 0;
      settings_used = 1;
      ref_now       = tdc_pkg::REF_RESET;
      arm_walk      = 0;
      pend_walk     = 0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // reset setting: all gains zero, drive must stay at zero
      offer(16'sd0, 16'sd0);
      offer(16'sh7FFF, 16'sh8000);
      offer(16'sh8000, 16'sh7FFF);

      // extreme gains and the lowest reference: loop outputs hit the 32-bit rails
      settle();
      write_reg(tdc_pkg::REG_REF_DEGREES,    24'hFFFE00);
      write_reg(tdc_pkg::REG_COEF_ERR_NOW,   24'h7FFFFF);
      write_reg(tdc_pkg::REG_COEF_ERR_PREV1, 24'h800000);
      write_reg(tdc_pkg::REG_COEF_ERR_PREV2, 24'h7FFFFF);
      write_reg(tdc_pkg::REG_COEF_OUT_PREV1, 24'h7FFFFF);
      write_reg(tdc_pkg::REG_COEF_OUT_PREV2, 24'h800000);
      write_reg(tdc_pkg::REG_PEND_GAIN,      24'h7FFFFF);
      settings_used++;
      offer(16'sh7FFF, 16'sh7FFF);
      offer(16'sh8000, 16'sh8000);
      offer(16'sd0, 16'sd0);
      offer(16'sh7FFF, 16'sh8000);
      offer(16'sh8000, 16'sh7FFF);

      // moderate gains: small drives, both clamps, pendulum term alone; unused index ignored
      settle();
      write_reg(tdc_pkg::REG_REF_DEGREES,    24'd90);
      write_reg(tdc_pkg::REG_COEF_ERR_NOW,   24'd65536);
      write_reg(tdc_pkg::REG_COEF_ERR_PREV1, 24'hFF8000);
      write_reg(tdc_pkg::REG_COEF_ERR_PREV2, 24'd16384);
      write_reg(tdc_pkg::REG_COEF_OUT_PREV1, 24'd32768);
      write_reg(tdc_pkg::REG_COEF_OUT_PREV2, 24'hFFC000);
      write_reg(tdc_pkg::REG_PEND_GAIN,      24'd262144);
      write_reg(REG_UNUSED, 24'hFFFFFF);
      settings_used++;
      offer(16'sd72, 16'sd0);
      offer(16'sd60, 16'sd0);
      offer(16'sd0, 16'sd0);
      offer(-16'sd2000, 16'sd0);
      offer(16'sd2000, 16'sd0);
      offer(16'sd72, 16'sd1000);
      offer(16'sd72, -16'sd1000);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         load_setting();
         burst_left = 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 30);
               if ($urandom_range(0, 3) != 0)
                  pause_sender($urandom_range(1, 12));
            end
            next_counts(a_cnt, p_cnt);
            offer(a_cnt, p_cnt);
            burst_left--;
         end
      end

      settle();
      repeat (40) @(negedge clock);

      $display("covered %0d ticks over %0d register settings, long output hold-offs: %0d",
               items_sent, settings_used, holds_done);
      $display("%0d drive items checked, %0d of them clamped, %0d mismatches",
               checked_count, clamped_count, fail_count);
      if (fail_count == 0 && pending_count == 0)
         $display("PASS two_loop_discrete_compensator");
      else
         $display("FAIL two_loop_discrete_compensator");
      $finish;
   end

endmodule
